@@ sv/quadratic_root_solver_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the quadratic root solver
// Concurrent assertion wrappers, removed in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_ROOT_SOLVER_UNIT_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define QRS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define QRS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define QRS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define QRS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ sv/qrs_pkg.sv @@
// ----------------------------------------------------------------------------
// Quadratic root solver package
// Case codes, widths and shared types.
// ----------------------------------------------------------------------------
`default_nettype none
package qrs_pkg;
  localparam int COEF_WIDTH_DEF     = 16;
  localparam int ROOT_FRAC_BITS_DEF = 16;
  localparam int ROOT_WIDTH         = 32;
  localparam int CASE_WIDTH         = 3;

  typedef enum logic [CASE_WIDTH-1:0] {
    CASE_INFINITE = 3'd0,
    CASE_NONE     = 3'd1,
    CASE_ONE      = 3'd2,
    CASE_TWO      = 3'd3,
    CASE_NO_REAL  = 3'd4
  } root_case_t;
endpackage
`default_nettype wire

@@ sv/quadratic_root_solver_unit.sv @@
// ----------------------------------------------------------------------------
// Quadratic root solver unit
// Path: inputs, products, discriminant, sqrt cells, numerators, dividers, output.
// Throughput: one coefficient set per cycle; the receiver cannot stall.
// Reset: synchronous active-low rst_n clears the valid chain; busy stays low.
// ----------------------------------------------------------------------------
`default_nettype none
`include "quadratic_root_solver_unit_assert.svh"
module quadratic_root_solver_unit #(
  parameter int COEF_WIDTH     = qrs_pkg::COEF_WIDTH_DEF,
  parameter int ROOT_FRAC_BITS = qrs_pkg::ROOT_FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic signed [COEF_WIDTH-1:0]      in_coef_a,
  input  wire logic signed [COEF_WIDTH-1:0]      in_coef_b,
  input  wire logic signed [COEF_WIDTH-1:0]      in_coef_c,
  output logic                                   out_strobe,
  output logic [qrs_pkg::CASE_WIDTH-1:0]         out_root_case,
  output logic signed [qrs_pkg::ROOT_WIDTH-1:0]  out_root_plus,
  output logic signed [qrs_pkg::ROOT_WIDTH-1:0]  out_root_minus,
  output logic                                   out_saturated
);
  localparam int CW   = COEF_WIDTH;
  localparam int F    = ROOT_FRAC_BITS;
  localparam int RW   = qrs_pkg::ROOT_WIDTH;
  localparam int DW   = 2*CW + 3;          // |D| magnitude bits
  localparam int RAD_W = (DW + 2*F) + ((DW + 2*F) % 2);
  localparam int RT_W  = RAD_W / 2;
  localparam int NSQ   = RT_W;
  localparam int DEN_W = CW + 1;           // |2a| or |b|
  localparam int NUM_A = (CW + F + 1 > RT_W) ? CW + F + 1 : RT_W;
  localparam int NUM_W = ((NUM_A > RW) ? NUM_A : RW) + 1;
  localparam int NDV   = NUM_W;

  typedef struct packed {
    logic                  vld;
    logic [2:0]            cs;
    logic                  neg;            // divisor negative
    logic [DEN_W-1:0]      den;
    logic signed [NUM_W:0] nb;             // signed numerator base
  } ctl_t;

  // stage 0: input register; stage 1: products
  logic                       v0_r;
  logic signed [CW-1:0]       a0_r, b0_r, c0_r;
  logic signed [2*CW-1:0]     bb1_r, ac1_r;
  logic                       v1_r;
  logic signed [CW-1:0]       a1_r, b1_r, c1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= start;
      v1_r <= v0_r;
    end
    a0_r  <= in_coef_a;
    b0_r  <= in_coef_b;
    c0_r  <= in_coef_c;
    bb1_r <= b0_r * b0_r;
    ac1_r <= a0_r * c0_r;
    a1_r  <= a0_r;
    b1_r  <= b0_r;
    c1_r  <= c0_r;
  end

  // stage 2: discriminant, case, numerator base, divisor
  logic signed [DW:0]     d_full;
  logic [2:0]             cs_nxt;
  logic [DEN_W-1:0]       den_nxt;
  logic                   neg_nxt;
  logic signed [NUM_W:0]  nb_nxt;
  ctl_t                   ctl2_r;
  logic [RAD_W-1:0]       rad2_r;

  always_comb begin
    d_full = (DW+1)'(bb1_r) - ((DW+1)'(ac1_r) <<< 2);
    den_nxt = '0;
    neg_nxt = 1'b0;
    nb_nxt  = '0;
    if (a1_r == '0) begin
      if (b1_r == '0) begin
        cs_nxt = (c1_r == '0) ? qrs_pkg::CASE_INFINITE : qrs_pkg::CASE_NONE;
      end else begin
        cs_nxt  = qrs_pkg::CASE_ONE;
        neg_nxt = b1_r[CW-1];
        den_nxt = b1_r[CW-1] ? DEN_W'(-(DEN_W'(b1_r))) : DEN_W'(b1_r);
        nb_nxt  = -((NUM_W+1)'(c1_r) <<< F);
      end
    end else begin
      if (d_full < 0)       cs_nxt = qrs_pkg::CASE_NO_REAL;
      else if (d_full == 0) cs_nxt = qrs_pkg::CASE_ONE;
      else                  cs_nxt = qrs_pkg::CASE_TWO;
      neg_nxt = a1_r[CW-1];
      den_nxt = a1_r[CW-1] ? DEN_W'(-({a1_r[CW-1], a1_r} <<< 1))
                           : DEN_W'({a1_r[CW-1], a1_r} <<< 1);
      nb_nxt  = -((NUM_W+1)'(b1_r) <<< F);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ctl2_r.vld <= 1'b0;
    else        ctl2_r.vld <= v1_r;
    ctl2_r.cs  <= cs_nxt;
    ctl2_r.neg <= neg_nxt;
    ctl2_r.den <= den_nxt;
    ctl2_r.nb  <= nb_nxt;
    rad2_r <= (cs_nxt == qrs_pkg::CASE_TWO)
              ? (RAD_W'(d_full[DW-1:0]) << (2*F)) : '0;
  end

  // square root cell chain
  logic [RAD_W-1:0] sq_rad  [0:NSQ];
  logic [RT_W+1:0]  sq_rem  [0:NSQ];
  logic [RT_W-1:0]  sq_root [0:NSQ];
  ctl_t             sq_ctl  [0:NSQ];

  assign sq_rad[0]  = rad2_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_ctl[0]  = ctl2_r;

  for (genvar i = 0; i < NSQ; i++) begin : g_sq
    qrs_sqrt_cell #(.RAD_W(RAD_W), .RT_W(RT_W), .IDX(NSQ-1-i)) u_cell (
      .clk   (clk),
      .rad_i (sq_rad[i]),
      .rem_i (sq_rem[i]),
      .root_i(sq_root[i]),
      .rad_o (sq_rad[i+1]),
      .rem_o (sq_rem[i+1]),
      .root_o(sq_root[i+1])
    );
    always_ff @(posedge clk) begin
      if (!rst_n) sq_ctl[i+1].vld <= 1'b0;
      else        sq_ctl[i+1].vld <= sq_ctl[i].vld;
      sq_ctl[i+1].cs  <= sq_ctl[i].cs;
      sq_ctl[i+1].neg <= sq_ctl[i].neg;
      sq_ctl[i+1].den <= sq_ctl[i].den;
      sq_ctl[i+1].nb  <= sq_ctl[i].nb;
    end
  end

  // numerators: sign-magnitude with divisor sign folded in
  logic signed [NUM_W+1:0] p_s, m_s;
  ctl_t                    ctl3_r;
  logic                    s1_r, s2_r;
  logic [NUM_W-1:0]        n1_r, n2_r;

  always_comb begin
    p_s = (NUM_W+2)'(sq_ctl[NSQ].nb) + (NUM_W+2)'(sq_root[NSQ]);
    m_s = (NUM_W+2)'(sq_ctl[NSQ].nb) - (NUM_W+2)'(sq_root[NSQ]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ctl3_r.vld <= 1'b0;
    else        ctl3_r.vld <= sq_ctl[NSQ].vld;
    ctl3_r.cs  <= sq_ctl[NSQ].cs;
    ctl3_r.neg <= sq_ctl[NSQ].neg;
    ctl3_r.den <= sq_ctl[NSQ].den;
    ctl3_r.nb  <= sq_ctl[NSQ].nb;
    s1_r <= p_s[NUM_W+1] ^ sq_ctl[NSQ].neg;
    s2_r <= m_s[NUM_W+1] ^ sq_ctl[NSQ].neg;
    n1_r <= p_s[NUM_W+1] ? NUM_W'(-p_s) : NUM_W'(p_s);
    n2_r <= m_s[NUM_W+1] ? NUM_W'(-m_s) : NUM_W'(m_s);
  end

  // divider cell chain
  logic [DEN_W-1:0] dv_den [0:NDV];
  logic [NUM_W-1:0] dv_n1  [0:NDV];
  logic [NUM_W-1:0] dv_n2  [0:NDV];
  logic [DEN_W:0]   dv_r1  [0:NDV];
  logic [DEN_W:0]   dv_r2  [0:NDV];
  logic [NUM_W-1:0] dv_q1  [0:NDV];
  logic [NUM_W-1:0] dv_q2  [0:NDV];
  logic             dv_v   [0:NDV];
  logic [2:0]       dv_cs  [0:NDV];
  logic             dv_s1  [0:NDV];
  logic             dv_s2  [0:NDV];

  assign dv_den[0] = ctl3_r.den;
  assign dv_n1[0]  = n1_r;
  assign dv_n2[0]  = n2_r;
  assign dv_r1[0]  = '0;
  assign dv_r2[0]  = '0;
  assign dv_q1[0]  = '0;
  assign dv_q2[0]  = '0;
  assign dv_v[0]   = ctl3_r.vld;
  assign dv_cs[0]  = ctl3_r.cs;
  assign dv_s1[0]  = s1_r;
  assign dv_s2[0]  = s2_r;

  for (genvar j = 0; j < NDV; j++) begin : g_dv
    qrs_div_cell #(.NUM_W(NUM_W), .DEN_W(DEN_W), .IDX(NDV-1-j)) u_cell (
      .clk  (clk),
      .den_i(dv_den[j]), .n1_i(dv_n1[j]), .n2_i(dv_n2[j]),
      .r1_i (dv_r1[j]),  .r2_i(dv_r2[j]), .q1_i(dv_q1[j]), .q2_i(dv_q2[j]),
      .den_o(dv_den[j+1]), .n1_o(dv_n1[j+1]), .n2_o(dv_n2[j+1]),
      .r1_o (dv_r1[j+1]),  .r2_o(dv_r2[j+1]), .q1_o(dv_q1[j+1]), .q2_o(dv_q2[j+1])
    );
    always_ff @(posedge clk) begin
      if (!rst_n) dv_v[j+1] <= 1'b0;
      else        dv_v[j+1] <= dv_v[j];
      dv_cs[j+1] <= dv_cs[j];
      dv_s1[j+1] <= dv_s1[j];
      dv_s2[j+1] <= dv_s2[j];
    end
  end

  // sign, saturation and output register
  localparam logic [NUM_W-1:0] POS_MAX = NUM_W'((64'd1 << (RW-1)) - 64'd1);
  localparam logic [NUM_W-1:0] NEG_MAX = NUM_W'(64'd1 << (RW-1));

  logic [2:0]    fcs;
  logic          use1, use2, c1, c2;
  logic [RW-1:0] r1, r2;

  always_comb begin
    fcs  = dv_cs[NDV];
    use1 = (fcs == qrs_pkg::CASE_ONE) || (fcs == qrs_pkg::CASE_TWO);
    use2 = (fcs == qrs_pkg::CASE_TWO);
    c1 = dv_s1[NDV] ? (dv_q1[NDV] > NEG_MAX) : (dv_q1[NDV] > POS_MAX);
    c2 = dv_s2[NDV] ? (dv_q2[NDV] > NEG_MAX) : (dv_q2[NDV] > POS_MAX);
    if (c1)              r1 = dv_s1[NDV] ? RW'(NEG_MAX) : RW'(POS_MAX);
    else if (dv_s1[NDV]) r1 = RW'(-dv_q1[NDV]);
    else                 r1 = RW'(dv_q1[NDV]);
    if (c2)              r2 = dv_s2[NDV] ? RW'(NEG_MAX) : RW'(POS_MAX);
    else if (dv_s2[NDV]) r2 = RW'(-dv_q2[NDV]);
    else                 r2 = RW'(dv_q2[NDV]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe <= 1'b0;
    else        out_strobe <= dv_v[NDV];
    out_root_case  <= fcs;
    out_root_plus  <= use1 ? r1 : '0;
    out_root_minus <= use2 ? r2 : '0;
    out_saturated  <= (use1 && c1) || (use2 && c2);
  end

  assign busy = 1'b0;

  `QRS_ASSERT_NXT(a_start_flows, clk, rst_n, start, v0_r, "accepted beat lost")
  `QRS_ASSERT_IMP(a_minus_zero, clk, rst_n,
    out_strobe && (out_root_case != qrs_pkg::CASE_TWO), out_root_minus == '0,
    "unused root nonzero")
  `QRS_ASSERT_IMP(a_case_range, clk, rst_n, out_strobe,
    out_root_case <= qrs_pkg::CASE_NO_REAL, "bad case code")
endmodule
`default_nettype wire

@@ sv/qrs_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// Square root cell
// One restoring step: takes two radicand bits, yields one root bit.
// ----------------------------------------------------------------------------
`default_nettype none
module qrs_sqrt_cell #(
  parameter int RAD_W = 64,
  parameter int RT_W  = 32,
  parameter int IDX   = 0
) (
  input  wire logic             clk,
  input  wire logic [RAD_W-1:0] rad_i,
  input  wire logic [RT_W+1:0]  rem_i,
  input  wire logic [RT_W-1:0]  root_i,
  output logic      [RAD_W-1:0] rad_o,
  output logic      [RT_W+1:0]  rem_o,
  output logic      [RT_W-1:0]  root_o
);
  logic [RT_W+1:0] rem_sh;
  logic [RT_W+1:0] trial;
  logic [RT_W-1:0] root_sh;
  logic [RAD_W-1:0] rad_r;
  logic [RT_W+1:0]  rem_r;
  logic [RT_W-1:0]  root_r;

  always_comb begin
    rem_sh  = {rem_i[RT_W-1:0], rad_i[2*IDX+1 -: 2]};
    root_sh = {root_i[RT_W-2:0], 1'b0};
    trial   = {1'b0, root_sh, 1'b1};
  end

  always_ff @(posedge clk) begin
    rad_r <= rad_i;
    if (rem_sh >= trial) begin
      rem_r  <= rem_sh - trial;
      root_r <= root_sh | {{(RT_W-1){1'b0}}, 1'b1};
    end else begin
      rem_r  <= rem_sh;
      root_r <= root_sh;
    end
  end

  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
endmodule
`default_nettype wire

@@ sv/qrs_div_cell.sv @@
// ----------------------------------------------------------------------------
// Divider cell
// One restoring step on two unsigned dividends sharing a divisor.
// ----------------------------------------------------------------------------
`default_nettype none
module qrs_div_cell #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 32,
  parameter int IDX   = 0
) (
  input  wire logic             clk,
  input  wire logic [DEN_W-1:0] den_i,
  input  wire logic [NUM_W-1:0] n1_i,
  input  wire logic [NUM_W-1:0] n2_i,
  input  wire logic [DEN_W:0]   r1_i,
  input  wire logic [DEN_W:0]   r2_i,
  input  wire logic [NUM_W-1:0] q1_i,
  input  wire logic [NUM_W-1:0] q2_i,
  output logic      [DEN_W-1:0] den_o,
  output logic      [NUM_W-1:0] n1_o,
  output logic      [NUM_W-1:0] n2_o,
  output logic      [DEN_W:0]   r1_o,
  output logic      [DEN_W:0]   r2_o,
  output logic      [NUM_W-1:0] q1_o,
  output logic      [NUM_W-1:0] q2_o
);
  logic [DEN_W+1:0] s1, s2, d;
  logic [DEN_W:0]   r1_nxt, r2_nxt;
  logic [NUM_W-1:0] q1_nxt, q2_nxt;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] n1_r, n2_r, q1_r, q2_r;
  logic [DEN_W:0]   r1_r, r2_r;

  always_comb begin
    d  = {2'b00, den_i};
    s1 = {r1_i, n1_i[IDX]};
    s2 = {r2_i, n2_i[IDX]};
    q1_nxt = q1_i;
    q2_nxt = q2_i;
    if (s1 >= d) begin
      r1_nxt = (DEN_W+1)'(s1 - d);
      q1_nxt[IDX] = 1'b1;
    end else begin
      r1_nxt = s1[DEN_W:0];
    end
    if (s2 >= d) begin
      r2_nxt = (DEN_W+1)'(s2 - d);
      q2_nxt[IDX] = 1'b1;
    end else begin
      r2_nxt = s2[DEN_W:0];
    end
  end

  always_ff @(posedge clk) begin
    den_r <= den_i;
    n1_r  <= n1_i;
    n2_r  <= n2_i;
    q1_r  <= q1_nxt;
    q2_r  <= q2_nxt;
    r1_r  <= r1_nxt;
    r2_r  <= r2_nxt;
  end

  assign den_o = den_r;
  assign n1_o  = n1_r;
  assign n2_o  = n2_r;
  assign r1_o  = r1_r;
  assign r2_o  = r2_r;
  assign q1_o  = q1_r;
  assign q2_o  = q2_r;
endmodule
`default_nettype wire
